/* rtl/sha256_pkg.sv */
// Package with SHA-256 constants and the sequencer state type.
`default_nettype none
package sha256_pkg;

    // Input word kinds.
    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_DIGEST  = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    // Initial hash values.
    localparam logic [31:0] SHA_INIT [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Round constants.
    localparam logic [31:0] SHA_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LOAD  = 5'b00010,
        S_ROUND = 5'b00100,
        S_FINAL = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

endpackage
`default_nettype wire

/* rtl/sha256_hash_engine_core.sv */
// Byte-stream SHA-256 engine with one shared round unit under a small sequencer.
// A data word is buffered; one that completes a 64-byte block is compressed
// (one load, 64 rounds at one round per cycle in the round unit, one chain add).
// A digest request runs one or two compressions of the padded tail, then emits
// eight output words. A restart reloads the initial hash values and clears the
// counts. Synchronous active-low reset does the same; no clearing pass is needed.
`default_nettype none
module sha256_hash_engine_core
    import sha256_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_kind,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_index,
    output logic             o_last
);

    t_state       r_state;
    t_state       n_state;
    logic [31:0]  r_chain [0:7];
    logic [31:0]  r_fin   [0:7];
    logic [31:0]  r_wv    [0:7];
    logic [31:0]  r_w     [0:15];
    logic [31:0]  r_buf   [0:15];
    logic [5:0]   r_fill;
    logic [63:0]  r_bytes;
    logic [5:0]   r_rnd;
    logic [2:0]   r_idx;
    logic         r_dig;
    logic         r_two;

    logic         in_acc;
    logic         out_acc;
    logic [63:0]  len_bits;
    logic [31:0]  pad1 [0:15];
    logic [31:0]  pad2 [0:15];
    logic [31:0]  sum  [0:7];
    logic [31:0]  t1;
    logic [31:0]  t2;
    logic [31:0]  w_new;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    assign in_acc   = i_valid && !o_stall;
    assign out_acc  = o_valid && !i_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign len_bits = {r_bytes[60:0], 3'b000};

    // Output words come straight from the final chain registers.
    assign o_valid       = (r_state == S_EMIT);
    assign o_digest_word = r_fin[r_idx];
    assign o_word_index  = r_idx;
    assign o_last        = (r_idx == 3'd7);

    // Padded tail blocks built from the pending bytes.
    always_comb begin
        logic [5:0] j;
        logic [7:0] b;
        for (int k = 0; k < 16; k++) begin
            for (int m = 0; m < 4; m++) begin
                j = 6'(k * 4 + m);
                if (j < r_fill) begin
                    b = r_buf[k][31 - 8 * m -: 8];
                end else if (j == r_fill) begin
                    b = 8'h80;
                end else begin
                    b = 8'h00;
                end
                pad1[k][31 - 8 * m -: 8] = b;
            end
            pad2[k] = 32'h0;
        end
        if (!r_two) begin
            pad1[14] = len_bits[63:32];
            pad1[15] = len_bits[31:0];
        end
        pad2[14] = len_bits[63:32];
        pad2[15] = len_bits[31:0];
    end

    // Shared round unit and message schedule step.
    always_comb begin
        t1 = (rotr(r_wv[4], 6) ^ rotr(r_wv[4], 11) ^ rotr(r_wv[4], 25))
           + ((r_wv[4] & r_wv[5]) ^ (~r_wv[4] & r_wv[6]))
           + r_wv[7] + SHA_K[r_rnd] + r_w[0];
        t2 = (rotr(r_wv[0], 2) ^ rotr(r_wv[0], 13) ^ rotr(r_wv[0], 22))
           + ((r_wv[0] & r_wv[1]) ^ (r_wv[0] & r_wv[2]) ^ (r_wv[1] & r_wv[2]));
        w_new = (rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10))
              + r_w[9]
              + (rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3))
              + r_w[0];
        for (int j = 0; j < 8; j++) begin
            sum[j] = (r_dig ? r_fin[j] : r_chain[j]) + r_wv[j];
        end
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_kind == KIND_DIGEST) begin
                    n_state = S_LOAD;
                end else if (in_acc && i_kind == KIND_DATA && r_fill == 6'd63) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD:  n_state = S_ROUND;
            S_ROUND: begin
                if (r_rnd == 6'd63) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                if (!r_dig) begin
                    n_state = S_IDLE;
                end else if (r_two) begin
                    n_state = S_ROUND;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_acc && r_idx == 3'd7) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= 6'd0;
            r_bytes <= 64'd0;
            r_rnd   <= 6'd0;
            r_idx   <= 3'd0;
            r_dig   <= 1'b0;
            r_two   <= 1'b0;
            for (int j = 0; j < 8; j++) begin
                r_chain[j] <= SHA_INIT[j];
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && in_acc) begin
                case (i_kind)
                    KIND_DATA: begin
                        r_fill  <= r_fill + 6'd1;
                        r_bytes <= r_bytes + 64'd1;
                    end
                    KIND_DIGEST: begin
                        r_dig <= 1'b1;
                        r_two <= (r_fill >= 6'd56);
                    end
                    KIND_RESTART: begin
                        r_fill  <= 6'd0;
                        r_bytes <= 64'd0;
                        for (int j = 0; j < 8; j++) begin
                            r_chain[j] <= SHA_INIT[j];
                        end
                    end
                    default: ;
                endcase
            end
            if (r_state == S_LOAD) begin
                r_rnd <= 6'd0;
            end else if (r_state == S_ROUND) begin
                r_rnd <= r_rnd + 6'd1;
            end
            if (r_state == S_FINAL) begin
                r_idx <= 3'd0;
                if (!r_dig) begin
                    for (int j = 0; j < 8; j++) begin
                        r_chain[j] <= sum[j];
                    end
                end else if (r_two) begin
                    r_two <= 1'b0;
                    r_rnd <= 6'd0;
                end
            end
            if (out_acc) begin
                r_idx <= r_idx + 3'd1;
                if (r_idx == 3'd7) begin
                    r_dig <= 1'b0;
                end
            end
        end
    end

    // Block buffer, schedule window, working variables and final chain.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_acc && i_kind == KIND_DATA) begin
            r_buf[r_fill[5:2]][31 - 8 * r_fill[1:0] -: 8] <= i_data_byte;
        end
        if (r_state == S_IDLE && in_acc && i_kind == KIND_DIGEST) begin
            for (int j = 0; j < 8; j++) begin
                r_fin[j] <= r_chain[j];
            end
        end
        unique case (r_state)
            S_LOAD: begin
                for (int k = 0; k < 16; k++) begin
                    r_w[k] <= r_dig ? pad1[k] : r_buf[k];
                end
                for (int j = 0; j < 8; j++) begin
                    r_wv[j] <= r_chain[j];
                end
            end
            S_ROUND: begin
                for (int k = 0; k < 15; k++) begin
                    r_w[k] <= r_w[k + 1];
                end
                r_w[15] <= w_new;
                for (int j = 1; j < 8; j++) begin
                    if (j != 4) begin
                        r_wv[j] <= r_wv[j - 1];
                    end
                end
                r_wv[4] <= r_wv[3] + t1;
                r_wv[0] <= t1 + t2;
            end
            S_FINAL: begin
                if (r_dig) begin
                    for (int j = 0; j < 8; j++) begin
                        r_fin[j] <= sum[j];
                        r_wv[j]  <= sum[j];
                    end
                    for (int k = 0; k < 16; k++) begin
                        r_w[k] <= pad2[k];
                    end
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    // Digest words only appear during a digest.
    a_emit_in_digest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_dig)
        else $error("digest word shown outside a digest");

    // The last round always hands over to the chain add.
    a_round_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND && r_rnd == 6'd63) |=> (r_state == S_FINAL))
        else $error("round count did not end the compression");

    // After the last digest word the output goes quiet.
    a_last_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_last) |=> !o_valid)
        else $error("output still valid after the last digest word");

    // No new word is taken while the round unit is busy.
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) |-> o_stall)
        else $error("input taken during compression");
`endif

endmodule
`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the byte-stream SHA-256 engine.
`timescale 1ns / 1ps
module tb;
    import sha256_pkg::*;

    // One input word and one digest output word.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
    } t_word;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last;
    } t_digest_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [1:0]  i_kind = KIND_DATA;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last;

    sha256_hash_engine_core u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_kind       (i_kind),
        .i_data_byte  (i_data_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_digest_word(o_digest_word),
        .o_word_index (o_word_index),
        .o_last       (o_last)
    );

    always #2 i_clk = ~i_clk;

    t_word       pending_words[$];
    t_digest_out expected_digest[$];
    int          mismatch_count = 0;
    bit          random_idle = 1'b1;
    bit          hold_sender = 1'b0;
    bit          stim_done = 1'b0;

    // Predictor state of the hashing engine.
    logic [31:0] chain_h[8];
    logic [7:0]  block_bytes[64];
    logic [6:0]  fill_count;
    logic [63:0] byte_total;

    function automatic logic [31:0] rotr32(logic [31:0] v, int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    // One SHA-256 compression of a 64-byte block into the given chain.
    task automatic sha_compress(input logic [7:0] blk[64], inout logic [31:0] h[8]);
        logic [31:0] w[64];
        logic [31:0] r[8];
        logic [31:0] s0, s1, t1, t2;
        for (int i = 0; i < 16; i++) begin
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        end
        for (int i = 16; i < 64; i++) begin
            s0 = rotr32(w[i-15], 7) ^ rotr32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr32(w[i-2], 17) ^ rotr32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
        end
        for (int j = 0; j < 8; j++) r[j] = h[j];
        for (int i = 0; i < 64; i++) begin
            t1 = (rotr32(r[4], 6) ^ rotr32(r[4], 11) ^ rotr32(r[4], 25))
                 + ((r[4] & r[5]) ^ (~r[4] & r[6])) + r[7] + SHA_K[i] + w[i];
            t2 = (rotr32(r[0], 2) ^ rotr32(r[0], 13) ^ rotr32(r[0], 22))
                 + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
            for (int j = 7; j >= 1; j--) r[j] = r[j-1];
            r[4] = r[4] + t1;
            r[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++) h[j] = h[j] + r[j];
    endtask

    task automatic restart_chain();
        for (int j = 0; j < 8; j++) chain_h[j] = SHA_INIT[j];
        fill_count = '0;
        byte_total = '0;
    endtask

    // Apply one accepted word to the predictor and queue any digest words.
    task automatic predict_word(input t_word wd);
        logic [7:0]  tail[64];
        logic [31:0] fin[8];
        logic [63:0] bit_len;
        t_digest_out dout;
        case (wd.kind)
            KIND_DATA: begin
                block_bytes[fill_count[5:0]] = wd.data_byte;
                fill_count = fill_count + 1;
                byte_total = byte_total + 1;
                if (fill_count >= 64) begin
                    sha_compress(block_bytes, chain_h);
                    fill_count = '0;
                end
            end
            KIND_RESTART: restart_chain();
            KIND_DIGEST: begin
                bit_len = byte_total << 3;
                for (int i = 0; i < 64; i++)
                    tail[i] = (i < fill_count) ? block_bytes[i] : 8'h00;
                tail[fill_count[5:0]] = 8'h80;
                for (int j = 0; j < 8; j++) fin[j] = chain_h[j];
                if (fill_count >= 56) begin
                    sha_compress(tail, fin);
                    for (int i = 0; i < 64; i++) tail[i] = 8'h00;
                end
                for (int i = 0; i < 8; i++) tail[56+i] = bit_len[63-8*i -: 8];
                sha_compress(tail, fin);
                for (int i = 0; i < 8; i++) begin
                    dout.digest_word = fin[i];
                    dout.word_index = 3'(i);
                    dout.last = (i == 7);
                    expected_digest.push_back(dout);
                end
            end
            default: ;
        endcase
    endtask

    // Driver: present queued words, idling at random.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || !o_stall) begin
                if (i_valid) predict_word('{kind: i_kind, data_byte: i_data_byte});
                if (pending_words.size() > 0 && !hold_sender
                        && !(random_idle && $urandom_range(99) < 30)) begin
                    i_valid <= 1'b1;
                    i_kind <= pending_words[0].kind;
                    i_data_byte <= pending_words[0].data_byte;
                    void'(pending_words.pop_front());
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted digest word and stall at random.
    always @(posedge i_clk) begin
        t_digest_out exp_w;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_digest.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Unexpected digest word %h index %0d", o_digest_word,
                                 o_word_index);
                end else begin
                    exp_w = expected_digest.pop_front();
                    if (exp_w !== {o_digest_word, o_word_index, o_last}) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("Mismatch: expected %h/%0d/%0d got %h/%0d/%0d",
                                     exp_w.digest_word, exp_w.word_index, exp_w.last,
                                     o_digest_word, o_word_index, o_last);
                    end
                end
            end
            i_stall <= random_idle && ($urandom_range(99) < 30);
        end
    end

    task automatic push_word(input logic [1:0] k, input logic [7:0] b);
        pending_words.push_back('{kind: k, data_byte: b});
    endtask

    task automatic wait_drained();
        while (pending_words.size() > 0 || i_valid || expected_digest.size() > 0)
            @(posedge i_clk);
    endtask

    // Stimulus and end of run.
    initial begin
        int n;
        restart_chain();
        for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty message, "abc", ignored kind, restart, two-byte message.
        push_word(KIND_DIGEST, 8'h00);
        push_word(KIND_DATA, 8'h61);
        push_word(KIND_DATA, 8'h62);
        push_word(KIND_DATA, 8'h63);
        push_word(2'd3, 8'hff);
        push_word(KIND_DIGEST, 8'hff);
        push_word(KIND_RESTART, 8'h5a);
        push_word(KIND_DATA, 8'hff);
        push_word(KIND_DATA, 8'h00);
        push_word(KIND_DIGEST, 8'h00);
        wait_drained();

        // Hold the sender while words are queued: a 56-byte tail, then a full 64-byte block.
        hold_sender = 1'b1;
        push_word(KIND_RESTART, 8'h00);
        for (int i = 0; i < 56; i++) push_word(KIND_DATA, 8'($urandom));
        push_word(KIND_DIGEST, 8'h00);
        for (int i = 0; i < 8; i++) push_word(KIND_DATA, 8'($urandom));
        push_word(KIND_DIGEST, 8'h00);
        repeat (20) @(posedge i_clk);
        hold_sender = 1'b0;
        wait_drained();

        // Random messages of mostly short length, with noise words.
        for (int m = 0; m < 12; m++) begin
            if (m == 4) random_idle = 1'b0;
            if (m == 7) random_idle = 1'b1;
            if ($urandom_range(3) != 0) push_word(KIND_RESTART, 8'($urandom));
            n = ($urandom_range(7) == 0) ? $urandom_range(20) : $urandom_range(6);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(15) == 0) push_word(2'd3, 8'($urandom));
                push_word(KIND_DATA, 8'($urandom));
            end
            push_word(KIND_DIGEST, 8'($urandom));
            if (m % 4 == 3) wait_drained();
        end
        wait_drained();
        repeat (200) @(posedge i_clk);
        if (mismatch_count == 0 && expected_digest.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end
endmodule
